FILE: design/ptrt_pkg.sv
// Package for the per-task run-time tracker.
// Holds widths, the slot row layout and the sequencer state type; no dependencies.
`timescale 1ns / 1ps

package ptrt_pkg;

	localparam int Tasks      = 64;
	localparam int SlotW      = $clog2(Tasks);
	localparam int TopMax     = 16;
	localparam int IdW        = 22;
	localparam int TimeW      = 64;
	localparam int CountW     = 32;
	localparam int RankW      = 4;
	localparam int TopW       = 5;
	localparam logic [TopW-1:0] TopReset = 5'd10;

	typedef struct packed {
		logic [IdW-1:0]   task_id;
		logic             started;
		logic             has_total;
		logic [TimeW-1:0] start_time;
		logic [TimeW-1:0] run_total;
	} row_t;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_SCAN    = 9'b000000010,
		ST_DIFF    = 9'b000000100,
		ST_ADD     = 9'b000001000,
		ST_WR_NEXT = 9'b000010000,
		ST_RSCAN   = 9'b000100000,
		ST_REND    = 9'b001000000,
		ST_FLUSH   = 9'b010000000,
		ST_SPARE   = 9'b100000000
	} state_t;

	localparam logic MODE_SWITCH = 1'b0;
	localparam logic MODE_REPORT = 1'b1;

	// True if (ta, ia) ranks ahead of (tb, ib).
	function automatic logic ranks_before(input logic [TimeW-1:0] ta, input logic [IdW-1:0] ia,
					      input logic [TimeW-1:0] tb, input logic [IdW-1:0] ib);
		ranks_before = (ta > tb) || ((ta == tb) && (ia < ib));
	endfunction

endpackage

FILE: design/ptrt_ram.sv
// Single-port slot table with a registered read: read data appears the cycle after the address.
// Depends on ptrt_pkg for the row layout and depth.
`timescale 1ns / 1ps

module ptrt_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ptrt_pkg::SlotW-1:0] addr,
	input  ptrt_pkg::row_t             wdata,
	output ptrt_pkg::row_t             rdata
);

	ptrt_pkg::row_t mem [ptrt_pkg::Tasks];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: design/per_task_runtime_top_tracker_top.sv
// Top level of the per-task run-time tracker: sequencer, slot-used flags and result register.
// Depends on ptrt_pkg and ptrt_ram.
`timescale 1ns / 1ps

// A switch event with prev_task unequal to next_task walks the 64-slot table once through
// the single RAM port, then adds the previous task's run time if it was started and writes
// the next task's row. A report walks the table to pick each emitted task in turn, for at
// most limit walks (top_count clamped to 1..16), then closes the report with a final beat.
// Results appear one cycle at a time on result_valid and cannot be held off; busy stays high
// until the report is done. The slot table needs no clearing pass: per-slot used flags are reset.
module per_task_runtime_top_tracker_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [ptrt_pkg::IdW-1:0]      prev_task,
	input  logic [ptrt_pkg::IdW-1:0]      next_task,
	input  logic [ptrt_pkg::TimeW-1:0]    timestamp,
	input  logic                          cfg_we,
	input  logic [ptrt_pkg::TopW-1:0]     cfg_wdata,
	output logic                          result_valid,
	output logic [ptrt_pkg::IdW-1:0]      task_id,
	output logic [ptrt_pkg::TimeW-1:0]    total_cycles,
	output logic [ptrt_pkg::RankW-1:0]    rank,
	output logic [ptrt_pkg::CountW-1:0]   switch_total,
	output logic                          entry_valid,
	output logic                          last
);

	localparam int CntW = ptrt_pkg::SlotW + 1;
	localparam logic [CntW-1:0] ScanEnd = CntW'(ptrt_pkg::Tasks + 1);

	ptrt_pkg::state_t state_q;
	logic [ptrt_pkg::TopW-1:0]   top_count_q;
	logic [ptrt_pkg::CountW-1:0] switch_count_q;
	logic [ptrt_pkg::Tasks-1:0]  slot_used_q;
	logic [CntW-1:0]             cnt_q;

	logic                        mode_q;
	logic [ptrt_pkg::IdW-1:0]    prev_q, next_q;
	logic [ptrt_pkg::TimeW-1:0]  ts_q, diff_q;

	logic                        rd_vld_s1;
	logic [ptrt_pkg::SlotW-1:0]  rd_idx_s1;

	logic                        prev_hit_q, next_hit_q, free_vld_q;
	logic [ptrt_pkg::SlotW-1:0]  prev_idx_q, next_idx_q, free_idx_q;
	ptrt_pkg::row_t              prev_row_q, next_row_q;

	logic                        best_vld_q;
	logic [ptrt_pkg::IdW-1:0]    best_id_q;
	logic [ptrt_pkg::TimeW-1:0]  best_tot_q;
	logic                        pend_q;
	logic [ptrt_pkg::IdW-1:0]    pend_id_q;
	logic [ptrt_pkg::TimeW-1:0]  pend_tot_q;
	logic [ptrt_pkg::RankW-1:0]  pend_rank_q;
	logic [ptrt_pkg::TopW-1:0]   n_q;

	logic                        mem_we;
	logic [ptrt_pkg::SlotW-1:0]  mem_addr;
	ptrt_pkg::row_t              mem_wdata, mem_rdata;
	logic [ptrt_pkg::TopW-1:0]   limit;
	logic                        row_used, cand;

	ptrt_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign busy = (state_q != ptrt_pkg::ST_IDLE);

	always_comb begin
		if (top_count_q == '0) begin
			limit = ptrt_pkg::TopW'(1);
		end else if (top_count_q > ptrt_pkg::TopW'(ptrt_pkg::TopMax)) begin
			limit = ptrt_pkg::TopW'(ptrt_pkg::TopMax);
		end else begin
			limit = top_count_q;
		end
	end

	assign row_used = slot_used_q[rd_idx_s1];
	// A candidate is a used slot with a total that ranks strictly behind the task picked last.
	assign cand = rd_vld_s1 && row_used && mem_rdata.has_total &&
		(!pend_q || ptrt_pkg::ranks_before(pend_tot_q, pend_id_q,
						   mem_rdata.run_total, mem_rdata.task_id));

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = cnt_q[ptrt_pkg::SlotW-1:0];
		mem_wdata = prev_row_q;
		case (state_q)
			ptrt_pkg::ST_ADD: begin
				mem_we    = 1'b1;
				mem_addr  = prev_idx_q;
				mem_wdata = prev_row_q;
				mem_wdata.started   = 1'b0;
				mem_wdata.has_total = 1'b1;
				mem_wdata.run_total = (prev_row_q.has_total ? prev_row_q.run_total : '0)
					+ diff_q;
			end
			ptrt_pkg::ST_WR_NEXT: begin
				if (next_hit_q) begin
					mem_we    = 1'b1;
					mem_addr  = next_idx_q;
					mem_wdata = next_row_q;
				end else begin
					mem_we    = free_vld_q;
					mem_addr  = free_idx_q;
					mem_wdata.task_id   = next_q;
					mem_wdata.has_total = 1'b0;
					mem_wdata.run_total = '0;
				end
				mem_wdata.started    = 1'b1;
				mem_wdata.start_time = ts_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ptrt_pkg::ST_IDLE;
			top_count_q    <= ptrt_pkg::TopReset;
			switch_count_q <= '0;
			slot_used_q    <= '0;
			cnt_q          <= '0;
			rd_vld_s1      <= 1'b0;
			result_valid   <= 1'b0;
			pend_q         <= 1'b0;
			best_vld_q     <= 1'b0;
			prev_hit_q     <= 1'b0;
			next_hit_q     <= 1'b0;
			free_vld_q     <= 1'b0;
			n_q            <= '0;
			mode_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				top_count_q <= cfg_wdata;
			end
			result_valid <= 1'b0;
			rd_vld_s1    <= ((state_q == ptrt_pkg::ST_SCAN) || (state_q == ptrt_pkg::ST_RSCAN))
				&& (cnt_q < CntW'(ptrt_pkg::Tasks));
			rd_idx_s1    <= cnt_q[ptrt_pkg::SlotW-1:0];

			case (state_q)
				ptrt_pkg::ST_IDLE: begin
					if (start) begin
						mode_q     <= mode;
						prev_q     <= prev_task;
						next_q     <= next_task;
						ts_q       <= timestamp;
						cnt_q      <= '0;
						prev_hit_q <= 1'b0;
						next_hit_q <= 1'b0;
						free_vld_q <= 1'b0;
						best_vld_q <= 1'b0;
						pend_q     <= 1'b0;
						n_q        <= '0;
						if (mode == ptrt_pkg::MODE_REPORT) begin
							state_q <= ptrt_pkg::ST_RSCAN;
						end else if (prev_task != next_task) begin
							state_q <= ptrt_pkg::ST_SCAN;
						end
					end
				end
				ptrt_pkg::ST_SCAN: begin
					cnt_q <= cnt_q + CntW'(1);
					if (rd_vld_s1) begin
						if (row_used && (mem_rdata.task_id == prev_q)) begin
							prev_hit_q <= 1'b1;
							prev_idx_q <= rd_idx_s1;
							prev_row_q <= mem_rdata;
						end
						if (row_used && (mem_rdata.task_id == next_q)) begin
							next_hit_q <= 1'b1;
							next_idx_q <= rd_idx_s1;
							next_row_q <= mem_rdata;
						end
						if (!row_used && !free_vld_q) begin
							free_vld_q <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
					end
					if (cnt_q == ScanEnd) begin
						state_q <= (prev_hit_q && prev_row_q.started) ?
							ptrt_pkg::ST_DIFF : ptrt_pkg::ST_WR_NEXT;
					end
				end
				ptrt_pkg::ST_DIFF: begin
					diff_q  <= ts_q - prev_row_q.start_time;
					state_q <= ptrt_pkg::ST_ADD;
				end
				ptrt_pkg::ST_ADD: begin
					state_q <= ptrt_pkg::ST_WR_NEXT;
				end
				ptrt_pkg::ST_WR_NEXT: begin
					if (!next_hit_q && free_vld_q) begin
						slot_used_q[free_idx_q] <= 1'b1;
					end
					switch_count_q <= switch_count_q + ptrt_pkg::CountW'(1);
					state_q        <= ptrt_pkg::ST_IDLE;
				end
				ptrt_pkg::ST_RSCAN: begin
					cnt_q <= cnt_q + CntW'(1);
					if (cand && (!best_vld_q || ptrt_pkg::ranks_before(mem_rdata.run_total,
						mem_rdata.task_id, best_tot_q, best_id_q))) begin
						best_vld_q <= 1'b1;
						best_id_q  <= mem_rdata.task_id;
						best_tot_q <= mem_rdata.run_total;
					end
					if (cnt_q == ScanEnd) begin
						state_q <= ptrt_pkg::ST_REND;
					end
				end
				ptrt_pkg::ST_REND: begin
					if (best_vld_q) begin
						// The held beat is known not to be the last one.
						if (pend_q) begin
							result_valid <= 1'b1;
							task_id      <= pend_id_q;
							total_cycles <= pend_tot_q;
							rank         <= pend_rank_q;
							entry_valid  <= 1'b1;
							last         <= 1'b0;
							switch_total <= switch_count_q;
						end
						pend_q      <= 1'b1;
						pend_id_q   <= best_id_q;
						pend_tot_q  <= best_tot_q;
						pend_rank_q <= n_q[ptrt_pkg::RankW-1:0];
						n_q         <= n_q + ptrt_pkg::TopW'(1);
						cnt_q       <= '0;
						best_vld_q  <= 1'b0;
						state_q     <= ((n_q + ptrt_pkg::TopW'(1)) == limit) ?
							ptrt_pkg::ST_FLUSH : ptrt_pkg::ST_RSCAN;
					end else begin
						state_q <= ptrt_pkg::ST_FLUSH;
					end
				end
				ptrt_pkg::ST_FLUSH: begin
					result_valid <= 1'b1;
					task_id      <= pend_q ? pend_id_q : '0;
					total_cycles <= pend_q ? pend_tot_q : '0;
					rank         <= pend_q ? pend_rank_q : '0;
					entry_valid  <= pend_q;
					last         <= 1'b1;
					switch_total <= switch_count_q;
					pend_q       <= 1'b0;
					state_q      <= ptrt_pkg::ST_IDLE;
				end
				default: begin
					state_q <= ptrt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	a_result_only_for_report: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (mode_q == ptrt_pkg::MODE_REPORT))
		else $error("result beat outside a report");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !entry_valid) |-> (last && (rank == '0)))
		else $error("empty report beat is not a lone final beat");

	a_rank_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (ptrt_pkg::TopW'(rank) < limit))
		else $error("rank beyond report limit");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptrt_pkg::ST_WR_NEXT) |=>
			(switch_count_q == $past(switch_count_q) + ptrt_pkg::CountW'(1)))
		else $error("switch count did not advance by one");

	a_no_scan_write: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ptrt_pkg::ST_SCAN) || (state_q == ptrt_pkg::ST_RSCAN)) |-> !mem_we)
		else $error("table written during a walk");

endmodule
